// ===== rtl/core/rgvc_pkg.sv =====
// shared types, constants and arithmetic helpers for the replaygain volume composer
package rgvc_pkg;

    typedef logic [30:0] mant_t;
    typedef logic signed [9:0] expo_t;

    typedef struct packed {
        logic  z;
        expo_t e;
        mant_t m;
    } nval_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMP_DB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_CLIP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_DB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_DB    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_ON     = 3'd6;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;

    localparam logic [16:0] VOLUME_RESET = 17'd10000;

    localparam logic [63:0] ONE30     = 64'd1073741824;
    localparam logic [63:0] GIGA      = 64'd1000000000;
    localparam logic [63:0] HALF_GIGA = 64'd500000000;

    localparam logic [31:0] LOG2_10_K =
        32'((64'd166096405 * 64'd4294967296 + HALF_GIGA) / GIGA);
    localparam logic [29:0] LN2_Q30   = 30'((64'd693147181 * ONE30 + HALF_GIGA) / GIGA);
    localparam mant_t       INV_1E12_M = 31'd1180591621;
    localparam logic [17:0] DIV6_RECIP = 18'd174763;

    localparam mant_t POW2_TAB [16] = '{
        31'((64'd1000000000 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1044273782 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1090507733 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1138788635 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1189207115 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1241857812 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1296839555 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1354255547 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1414213562 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1476826146 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1542210825 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1610490332 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1681792831 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1756252160 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1834008086 * ONE30 + HALF_GIGA) / GIGA),
        31'((64'd1915206561 * ONE30 + HALF_GIGA) / GIGA)
    };

    // product of two normalised values, rounded back to 30 fraction bits
    function automatic nval_t nmul(input nval_t a, input nval_t b);
        logic [61:0] prod;
        logic [32:0] rnd;
        nval_t       r;
        prod = 62'(a.m) * 62'(b.m);
        rnd  = 33'((prod + 62'd536870912) >> 30);
        r.z  = a.z | b.z;
        if (rnd[31])
        begin
            r.m = 31'((rnd + 33'd1) >> 1);
            r.e = a.e + b.e + 10'sd1;
        end
        else
        begin
            r.m = rnd[30:0];
            r.e = a.e + b.e;
        end
        return r;
    endfunction

    function automatic logic nless(input nval_t a, input nval_t b);
        logic r;
        if (a.e != b.e)
            r = a.e < b.e;
        else
            r = a.m < b.m;
        return r;
    endfunction

    // Q16.16 with half-up rounding and saturation
    function automatic logic [31:0] to_q16(input nval_t a);
        expo_t       sh;
        logic [32:0] sum;
        logic [31:0] v;
        sh  = 10'sd14 - a.e;
        sum = '0;
        v   = '0;
        priority if (a.z)
            v = '0;
        else if (a.e >= 10'sd16)
            v = '1;
        else if (a.e == 10'sd15)
            v = {a.m, 1'b0};
        else if (a.e == 10'sd14)
            v = {1'b0, a.m};
        else if (sh <= 10'sd31)
        begin
            sum = {2'b00, a.m} + (33'd1 << (sh[4:0] - 5'd1));
            v   = 32'(sum >> sh[4:0]);
        end
        else
            v = '0;
        return v;
    endfunction

endpackage

// ===== rtl/core/replaygain_volume_composer.sv =====
// top level: replaygain factor and playback gain pipeline
//
//  channel  | transfer when       | signals
//  ---------+---------------------+------------------------------------------------
//  record   | start && !busy      | tags_present, track/album gain and peak
//  result   | done (one cycle)    | total_gain, rg_factor
//  config   | cfg_we              | cfg_idx, cfg_wdata
//
//  one record a cycle; results come out in the order of their records
//  the longest path runs through the reciprocal divider (nine stages) ahead of two multiplies
//  busy is always low; results cannot be held off
//  rst_n clears the valid bits and sets the configuration registers to their reset values
module replaygain_volume_composer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              tags_present,
    input  logic signed [15:0]                track_gain_db,
    input  logic [23:0]                       track_peak_lin,
    input  logic signed [15:0]                album_gain_db,
    input  logic [23:0]                       album_peak_lin,
    input  logic                              cfg_we,
    input  logic [rgvc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rgvc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                              done,
    output logic [31:0]                       total_gain,
    output logic [31:0]                       rg_factor
);
    import rgvc_pkg::*;

    localparam int LAT = 14;

    logic [1:0]         rg_mode_reg;
    logic signed [15:0] preamp_reg;
    logic               allow_clip_reg;
    logic signed [15:0] fallback_reg;
    logic [16:0]        volume_reg;
    logic signed [15:0] extra_reg;
    logic               mute_on_reg;

    logic [12:0]        vld_reg;
    logic               done_reg;

    logic signed [16:0] x_reg   [4];
    logic [9:0]         len_reg;
    logic [23:0]        pk_reg;

    nval_t              fac_reg, fac12_reg, fac13_reg;
    nval_t              prod_reg, tot_reg;
    logic [31:0]        total_gain_reg, rg_factor_reg;

    logic               accept;
    logic               use_rg;
    logic               trk;
    logic signed [15:0] g_sel;
    logic [23:0]        pk_sel;
    logic signed [16:0] x_next;
    logic               len_next;

    nval_t              lim, fac, vol, extra;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        use_rg   = (rg_mode_reg != MODE_OFF) && tags_present;
        trk      = (rg_mode_reg == MODE_TRACK);
        g_sel    = trk ? track_gain_db : album_gain_db;
        pk_sel   = trk ? track_peak_lin : album_peak_lin;
        x_next   = use_rg ? 17'(g_sel) + 17'(preamp_reg) : 17'(fallback_reg);
        len_next = use_rg && !allow_clip_reg && (pk_sel != '0);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rg_mode_reg    <= MODE_OFF;
            preamp_reg     <= '0;
            allow_clip_reg <= 1'b0;
            fallback_reg   <= '0;
            volume_reg     <= VOLUME_RESET;
            extra_reg      <= '0;
            mute_on_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_RG_MODE:     rg_mode_reg    <= cfg_wdata[1:0];
                REG_PREAMP_DB:   preamp_reg     <= cfg_wdata[15:0];
                REG_ALLOW_CLIP:  allow_clip_reg <= cfg_wdata[0];
                REG_FALLBACK_DB: fallback_reg   <= cfg_wdata[15:0];
                REG_VOLUME:      volume_reg     <= cfg_wdata;
                REG_EXTRA_DB:    extra_reg      <= cfg_wdata[15:0];
                REG_MUTE_ON:     mute_on_reg    <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[11:0], accept};
            done_reg <= vld_reg[12];
        end
    end

    rgvc_recip u_recip (
        .clk  (clk),
        .peak (pk_reg),
        .lim  (lim)
    );

    rgvc_dblin u_fac (
        .clk (clk),
        .db  (x_reg[3]),
        .lin (fac)
    );

    rgvc_dblin u_extra (
        .clk (clk),
        .db  (17'(extra_reg)),
        .lin (extra)
    );

    rgvc_volume u_volume (
        .clk    (clk),
        .volume (volume_reg),
        .vol    (vol)
    );

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x_next;
        for (int s = 1; s < 4; s++)
            x_reg[s] <= x_reg[s-1];
        len_reg <= {len_reg[8:0], len_next};
        pk_reg  <= pk_sel;

        fac_reg   <= (len_reg[9] && nless(lim, fac)) ? lim : fac;
        prod_reg  <= nmul(vol, fac_reg);
        fac12_reg <= fac_reg;
        tot_reg   <= nmul(prod_reg, extra);
        fac13_reg <= fac12_reg;

        total_gain_reg <= mute_on_reg ? '0 : to_q16(tot_reg);
        rg_factor_reg  <= to_q16(fac13_reg);
    end

    assign done       = done_reg;
    assign total_gain = total_gain_reg;
    assign rg_factor  = rg_factor_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result missing after record transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching record");

    a_fac_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[10] |-> fac_reg.m[30])
        else $error("selected factor not normalised");

endmodule

// ===== rtl/core/rgvc_dblin.sv =====
// six-stage pipelined 10^(db/20) unit, db in Q8.8
module rgvc_dblin (
    input  logic                clk,
    input  logic signed [16:0]  db,
    output rgvc_pkg::nval_t     lin
);
    import rgvc_pkg::*;

    expo_t        e1_reg, e2_reg, e3_reg, e4_reg, e5_reg;
    logic [3:0]   idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [25:0]  r1_reg;
    logic [25:0]  y2_reg, y3_reg, y4_reg;
    logic [21:0]  sq3_reg, sq4_reg;
    logic [17:0]  cu4_reg;
    logic [30:0]  p5_reg;
    nval_t        lin_reg;

    logic signed [49:0] t_full;
    logic [55:0]        y_full;
    logic [51:0]        sq_full;
    logic [47:0]        cu_full;
    logic [35:0]        d6_full;
    logic [30:0]        p_next;
    logic [62:0]        m_full;
    logic [32:0]        m_rnd;
    nval_t              lin_next;

    always_comb
    begin
        t_full  = 50'(db) * $signed({18'd0, LOG2_10_K});
        y_full  = 56'(r1_reg) * 56'(LN2_Q30) + 56'd536870912;
        sq_full = 52'(y2_reg) * 52'(y2_reg) + 52'd536870912;
        cu_full = 48'(sq3_reg) * 48'(y3_reg) + 48'd536870912;
        d6_full = 36'(cu4_reg) * 36'(DIV6_RECIP);
        p_next  = 31'(ONE30) + 31'(y4_reg) + 31'(sq4_reg >> 1) + 31'(d6_full[35:20]);
        m_full  = 63'(POW2_TAB[idx5_reg]) * 63'(p5_reg) + 63'd536870912;
        m_rnd   = m_full[62:30];
        lin_next.z = 1'b0;
        if (m_rnd[31])
        begin
            lin_next.m = 31'((m_rnd + 33'd1) >> 1);
            lin_next.e = e5_reg + 10'sd1;
        end
        else
        begin
            lin_next.m = m_rnd[30:0];
            lin_next.e = e5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg   <= t_full[49:40];
        idx1_reg <= t_full[39:36];
        r1_reg   <= t_full[35:10];

        e2_reg   <= e1_reg;
        idx2_reg <= idx1_reg;
        y2_reg   <= y_full[55:30];

        e3_reg   <= e2_reg;
        idx3_reg <= idx2_reg;
        y3_reg   <= y2_reg;
        sq3_reg  <= sq_full[51:30];

        e4_reg   <= e3_reg;
        idx4_reg <= idx3_reg;
        y4_reg   <= y3_reg;
        sq4_reg  <= sq3_reg;
        cu4_reg  <= cu_full[47:30];

        e5_reg   <= e4_reg;
        idx5_reg <= idx4_reg;
        p5_reg   <= p_next;

        lin_reg  <= lin_next;
    end

    assign lin = lin_reg;

endmodule

// ===== rtl/core/rgvc_recip.sv =====
// nine-stage pipelined reciprocal of a Q8.16 peak, four quotient bits per divide stage
module rgvc_recip (
    input  logic             clk,
    input  logic [23:0]      peak,
    output rgvc_pkg::nval_t  lim
);
    import rgvc_pkg::*;

    localparam int DIV_STAGES = 8;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } div_t;

    logic [4:0]  msb;
    mant_t       nm_next;
    mant_t       nm_reg;
    logic [4:0]  b_reg;

    div_t        st_reg  [DIV_STAGES];
    mant_t       dm_reg  [DIV_STAGES];
    logic [4:0]  db_reg  [DIV_STAGES];

    logic [31:0] q_fin;

    function automatic div_t step4(input div_t s, input mant_t d);
        div_t r;
        r = s;
        for (int k = 0; k < 4; k++)
        begin
            r.rem = {r.rem[30:0], r.low[31]};
            r.low = {r.low[30:0], 1'b0};
            if (r.rem >= {1'b0, d})
            begin
                r.rem = r.rem - {1'b0, d};
                r.quo = {r.quo[30:0], 1'b1};
            end
            else
                r.quo = {r.quo[30:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (peak[i])
                msb = 5'(i);
        end
        nm_next = 31'(peak) << (5'd30 - msb);
    end

    always_ff @(posedge clk)
    begin
        nm_reg <= nm_next;
        b_reg  <= msb;
        st_reg[0] <= step4('{rem: 32'd536870912, low: {2'b00, nm_reg[30:1]}, quo: '0}, nm_reg);
        dm_reg[0] <= nm_reg;
        db_reg[0] <= b_reg;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            st_reg[s] <= step4(st_reg[s-1], dm_reg[s-1]);
            dm_reg[s] <= dm_reg[s-1];
            db_reg[s] <= db_reg[s-1];
        end
    end

    always_comb
    begin
        q_fin = st_reg[DIV_STAGES-1].quo;
        lim.z = 1'b0;
        lim.m = q_fin[31] ? q_fin[31:1] : q_fin[30:0];
        lim.e = 10'sd15 - $signed({5'd0, db_reg[DIV_STAGES-1]})
                + $signed({9'd0, q_fin[31]});
    end

endmodule

// ===== rtl/core/rgvc_volume.sv =====
// five-stage volume cube, normalised and scaled by 1e-12
module rgvc_volume (
    input  logic             clk,
    input  logic [16:0]      volume,
    output rgvc_pkg::nval_t  vol
);
    import rgvc_pkg::*;

    localparam nval_t SCALE = '{z: 1'b0, e: -10'sd40, m: INV_1E12_M};

    logic [33:0] sq_reg;
    logic [16:0] v1_reg;
    logic [50:0] cu_reg;
    logic [50:0] cu3_reg;
    logic [5:0]  b3_reg;
    logic        z3_reg;
    nval_t       n4_reg;
    nval_t       vol_reg;

    logic [5:0]  msb;
    logic [5:0]  sh;
    logic [51:0] rsum;
    logic [31:0] mm;
    nval_t       n_next;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 51; i++)
        begin
            if (cu_reg[i])
                msb = 6'(i);
        end
    end

    always_comb
    begin
        sh   = b3_reg - 6'd30;
        rsum = '0;
        mm   = '0;
        n_next.z = z3_reg;
        if (b3_reg > 6'd30)
        begin
            rsum = 52'(cu3_reg) + (52'd1 << (sh - 6'd1));
            mm   = 32'(rsum >> sh);
            if (mm[31])
            begin
                n_next.m = mm[31:1];
                n_next.e = $signed({4'd0, b3_reg}) + 10'sd1;
            end
            else
            begin
                n_next.m = mm[30:0];
                n_next.e = $signed({4'd0, b3_reg});
            end
        end
        else
        begin
            n_next.m = cu3_reg[30:0] << (6'd30 - b3_reg);
            n_next.e = $signed({4'd0, b3_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= 34'(volume) * 34'(volume);
        v1_reg  <= volume;
        cu_reg  <= 51'(sq_reg) * 51'(v1_reg);
        cu3_reg <= cu_reg;
        b3_reg  <= msb;
        z3_reg  <= (cu_reg == '0);
        n4_reg  <= n_next;
        vol_reg <= nmul(n4_reg, SCALE);
    end

    assign vol = vol_reg;

endmodule

// ===== test/tb_replaygain_volume_composer.sv =====
// self-checking testbench for the replaygain volume composer
module tb_replaygain_volume_composer;
    timeunit 1ns;
    timeprecision 1ps;
    import rgvc_pkg::*;

    typedef struct {
        logic [63:0] m;
        int          e;
        bit          z;
    } lin_t;

    typedef struct {
        logic               tags;
        logic signed [15:0] tgain;
        logic [23:0]        tpeak;
        logic signed [15:0] again;
        logic [23:0]        apeak;
    } record_t;

    typedef struct {
        logic [31:0] total;
        logic [31:0] factor;
    } gains_t;

    localparam logic [63:0] K_Q32 = (64'd166096405 * 64'd4294967296 + 64'd500000000)
                                    / 64'd1000000000;
    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic tags_present = 1'b0;
    logic signed [15:0] track_gain_db = '0;
    logic [23:0] track_peak_lin = '0;
    logic signed [15:0] album_gain_db = '0;
    logic [23:0] album_peak_lin = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic done;
    logic [31:0] total_gain;
    logic [31:0] rg_factor;

    logic [1:0]  m_mode = MODE_OFF;
    logic [15:0] m_preamp = '0;
    logic        m_clip = 1'b0;
    logic [15:0] m_fallback = '0;
    logic [16:0] m_volume = VOLUME_RESET;
    logic [15:0] m_extra = '0;
    logic        m_mute = 1'b0;

    record_t pending[$];
    gains_t  expected_gains[$];
    int gap = 0;
    int mismatches = 0;
    int cycles = 0;

    replaygain_volume_composer i_dut (.*);

    always #10 clk = ~clk;

    function automatic lin_t lin_norm(logic [63:0] x, int e0);
        lin_t r;
        int b;
        logic [63:0] t;
        r = '{0, 0, 1'b1};
        if (x == 0)
            return r;
        b = 0;
        for (t = x; t > 1; t = t >> 1)
            b++;
        r.z = 1'b0;
        r.e = e0 + b;
        if (b > 30)
        begin
            r.m = (x + (64'd1 << (b - 31))) >> (b - 30);
            if (r.m >= (ONE30 << 1))
            begin
                r.m = r.m >> 1;
                r.e++;
            end
        end
        else
            r.m = x << (30 - b);
        return r;
    endfunction

    function automatic lin_t lin_mul(lin_t a, lin_t b);
        lin_t r;
        r = '{0, 0, 1'b1};
        if (a.z || b.z)
            return r;
        r.z = 1'b0;
        r.m = (a.m * b.m + (ONE30 >> 1)) >> 30;
        r.e = a.e + b.e;
        if (r.m >= (ONE30 << 1))
        begin
            r.m = (r.m + 1) >> 1;
            r.e++;
        end
        return r;
    endfunction

    function automatic lin_t db_to_lin(int db);
        longint t;
        logic [63:0] u, r30, y, y2, y3, p;
        lin_t r;
        t = longint'(db) * longint'(K_Q32);
        u = 64'(t + (longint'(64) <<< 40));
        r30 = {28'd0, u[35:0]} >> 10;
        y = (r30 * 64'(LN2_Q30) + (ONE30 >> 1)) >> 30;
        y2 = (y * y + (ONE30 >> 1)) >> 30;
        y3 = (y2 * y + (ONE30 >> 1)) >> 30;
        p = ONE30 + y + (y2 >> 1) + y3 / 6;
        r.z = 1'b0;
        r.m = (64'(POW2_TAB[u[39:36]]) * p + (ONE30 >> 1)) >> 30;
        r.e = int'(u >> 40) - 64;
        if (r.m >= (ONE30 << 1))
        begin
            r.m = (r.m + 1) >> 1;
            r.e++;
        end
        return r;
    endfunction

    function automatic lin_t peak_recip(logic [23:0] pk);
        lin_t a, r;
        a = lin_norm(64'(pk), 0);
        r.z = 1'b0;
        r.m = ((64'd1 << 61) + (a.m >> 1)) / a.m;
        r.e = 15 - a.e;
        if (r.m >= (ONE30 << 1))
        begin
            r.m = r.m >> 1;
            r.e++;
        end
        return r;
    endfunction

    function automatic logic [31:0] lin_to_q16(lin_t a);
        int sh;
        logic [63:0] v;
        if (a.z)
            return '0;
        if (a.e >= 16)
            return '1;
        sh = 14 - a.e;
        if (sh <= 0)
            v = a.m << (-sh);
        else if (sh > 40)
            return '0;
        else
            v = (a.m + (64'd1 << (sh - 1))) >> sh;
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic gains_t compose_gains(record_t rec);
        lin_t factor, lim, vol, scale;
        logic [63:0] v;
        logic signed [15:0] g;
        logic [23:0] pk;
        gains_t res;
        if (m_mode != MODE_OFF && rec.tags)
        begin
            g  = (m_mode == MODE_TRACK) ? rec.tgain : rec.again;
            pk = (m_mode == MODE_TRACK) ? rec.tpeak : rec.apeak;
            factor = db_to_lin(int'(g) + int'($signed(m_preamp)));
            if (!m_clip && pk != 0)
            begin
                lim = peak_recip(pk);
                if (lim.e < factor.e || (lim.e == factor.e && lim.m < factor.m))
                    factor = lim;
            end
        end
        else
            factor = db_to_lin(int'($signed(m_fallback)));
        v = 64'(m_volume);
        scale = '{64'(INV_1E12_M), -40, 1'b0};
        vol = lin_mul(lin_norm(v * v * v, 0), scale);
        res.total = m_mute ? '0 :
            lin_to_q16(lin_mul(lin_mul(vol, factor), db_to_lin(int'($signed(m_extra)))));
        res.factor = lin_to_q16(factor);
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (gap > 0)
        begin
            gap <= gap - 1;
            start <= 1'b0;
        end
        else if (pending.size() > 0)
        begin
            start <= 1'b1;
            tags_present <= pending[0].tags;
            track_gain_db <= pending[0].tgain;
            track_peak_lin <= pending[0].tpeak;
            album_gain_db <= pending[0].again;
            album_peak_lin <= pending[0].apeak;
        end
        else
            start <= 1'b0;
    end

    // monitor and register shadow
    always @(posedge clk)
    begin
        gains_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL replaygain_volume_composer");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_gains.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result total %h factor %h", total_gain, rg_factor);
                end
                else
                begin
                    want = expected_gains.pop_front();
                    if (want.total !== total_gain || want.factor !== rg_factor)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp total %h factor %h, got total %h factor %h",
                                     want.total, want.factor, total_gain, rg_factor);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_gains.push_back(compose_gains(pending.pop_front()));
                if ($urandom_range(0, 9) == 0)
                    gap <= $urandom_range(5, 40);
                else if ($urandom_range(0, 2) == 0)
                    gap <= $urandom_range(1, 3);
                else
                    gap <= 0;
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_RG_MODE:     m_mode <= cfg_wdata[1:0];
                    REG_PREAMP_DB:   m_preamp <= cfg_wdata[15:0];
                    REG_ALLOW_CLIP:  m_clip <= cfg_wdata[0];
                    REG_FALLBACK_DB: m_fallback <= cfg_wdata[15:0];
                    REG_VOLUME:      m_volume <= cfg_wdata[16:0];
                    REG_EXTRA_DB:    m_extra <= cfg_wdata[15:0];
                    REG_MUTE_ON:     m_mute <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || expected_gains.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic setup(logic [1:0] mode, logic [15:0] pre, logic clip, logic [15:0] fb,
                         logic [16:0] vol, logic [15:0] extra, logic mute);
        write_reg(REG_RG_MODE, 17'(mode));
        write_reg(REG_PREAMP_DB, 17'(pre));
        write_reg(REG_ALLOW_CLIP, 17'(clip));
        write_reg(REG_FALLBACK_DB, 17'(fb));
        write_reg(REG_VOLUME, vol);
        write_reg(REG_EXTRA_DB, 17'(extra));
        write_reg(REG_MUTE_ON, 17'(mute));
    endtask

    function automatic logic [15:0] rand_db();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) :
               16'($signed($urandom_range(0, 10240)) - 5120);
    endfunction

    function automatic logic [23:0] rand_peak();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(1, 24'hFFFFFF));
            1: return 24'($urandom_range(1, 1000));
            default: return 24'($urandom_range(16384, 131072));
        endcase
    endfunction

    task automatic add_random(int n);
        record_t r;
        repeat (n)
        begin
            r.tags = ($urandom_range(0, 4) != 0);
            r.tgain = rand_db();
            r.tpeak = rand_peak();
            r.again = rand_db();
            r.apeak = rand_peak();
            pending.push_back(r);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed records under reset values and then track mode
        for (int md = 0; md < 2; md++)
        begin
            if (md == 1)
                setup(MODE_TRACK, 16'h0000, 1'b0, 16'h0000, VOLUME_RESET, 16'h0000, 1'b0);
            pending.push_back('{1'b1, 16'sh7FFF, 24'd1, -16'sd32768, 24'hFFFFFF});
            pending.push_back('{1'b1, -16'sd32768, 24'hFFFFFF, 16'sh7FFF, 24'd1});
            pending.push_back('{1'b1, 16'sd0, 24'd65536, 16'sd0, 24'd65536});
            pending.push_back('{1'b1, 16'sd1536, 24'd0, 16'sd1536, 24'd0});
            pending.push_back('{1'b0, 16'sd2560, 24'd32768, 16'sd2560, 24'd32768});
            pending.push_back('{1'b1, 16'sd1536, 24'd40000, -16'sd1536, 24'd90000});
            wait_idle();
        end
        // mode three reads as album, and a write past the last register is dropped
        setup(2'd3, 16'h7FFF, 1'b1, 16'h8000, 17'd100000, 16'h7FFF, 1'b0);
        write_reg(3'd7, 17'h1FFFF);
        add_random(6);
        wait_idle();
        setup(2'd2, 16'h8000, 1'b0, 16'h7FFF, 17'd0, 16'h8000, 1'b1);
        add_random(6);
        wait_idle();

        for (int ph = 0; ph < 10; ph++)
        begin
            setup(2'($urandom_range(0, 3)), rand_db(), 1'($urandom),
                  rand_db(),
                  ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                              : 17'($urandom_range(0, 100000)),
                  rand_db(), ($urandom_range(0, 5) == 0));
            add_random(185);
            wait_idle();
        end

        if (mismatches == 0 && expected_gains.size() == 0)
            $display("PASS replaygain_volume_composer");
        else
            $display("FAIL replaygain_volume_composer");
        $finish;
    end
endmodule
